FILE: hw/rtl/gbp_pkg.sv
// shared types, constants and the counter update rule of the gshare predictor
`default_nettype none

package gbp_pkg;

  // width of the branch address field
  localparam int unsigned PcWidth = 12;

  // two-bit pattern counter
  typedef logic [1:0] ctr_t;

  localparam ctr_t CtrStrongNt = 2'd0;
  localparam ctr_t CtrWeakNt   = 2'd1;
  localparam ctr_t CtrWeakT    = 2'd2;
  localparam ctr_t CtrStrongT  = 2'd3;

  // jump rule: taken from weak not taken goes straight to strong taken,
  // not taken from weak taken goes straight to strong not taken
  function automatic ctr_t next_counter(input ctr_t c, input logic taken);
    ctr_t n;
    n = c;
    unique case (c)
      CtrStrongNt: n = taken ? CtrWeakNt  : CtrStrongNt;
      CtrWeakNt:   n = taken ? CtrStrongT : CtrStrongNt;
      CtrWeakT:    n = taken ? CtrStrongT : CtrStrongNt;
      CtrStrongT:  n = taken ? CtrStrongT : CtrWeakT;
      default:     n = c;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/gbp_if.sv
// valid/ready channels for resolved branch items and prediction result items
`default_nettype none

interface gbp_br_if;
  logic                           valid;
  logic                           ready;
  logic [gbp_pkg::PcWidth-1:0]    pc_low_bits;
  logic                           taken;

  modport source (output valid, output pc_low_bits, output taken, input ready);
  modport sink   (input valid, input pc_low_bits, input taken, output ready);
endinterface

interface gbp_res_if;
  logic valid;
  logic ready;
  logic prediction;
  logic mispredicted;

  modport source (output valid, output prediction, output mispredicted, input ready);
  modport sink   (input valid, input prediction, input mispredicted, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/gbp_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none

module gbp_ram #(
  parameter int unsigned Width = 2,
  parameter int unsigned Depth = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, data held while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: hw/rtl/gshare_branch_predictor.sv
// gshare branch direction predictor with 2-bit jump-rule counters
`default_nettype none

// Takes one resolved branch item per cycle and returns one result item per
// branch: the prediction the counter table gave before the update, and a
// mispredict flag. The table index is the branch address XOR the global
// history, cut to INDEX_BITS. The counter table sits in a ram with a
// registered read, so an accepted item goes through the read stage and
// then the result register; a read-modify-write to the same entry by
// back-to-back items is forwarded, so throughput is one item per cycle
// as long as results are taken. After reset the block runs a clearing
// pass that sets every counter to weakly not taken, one entry per cycle,
// during which no item is accepted.
module gshare_branch_predictor #(
  parameter int unsigned INDEX_BITS   = 12,
  parameter int unsigned HISTORY_BITS = 12
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  gbp_br_if.sink   br_i,
  gbp_res_if.source res_o
);

  localparam int unsigned Depth = 2 ** INDEX_BITS;
  localparam int unsigned ExtW  = INDEX_BITS + gbp_pkg::PcWidth + HISTORY_BITS;

  // clearing pass state
  logic                  clearing_q, clearing_d;
  logic [INDEX_BITS-1:0] clr_idx_q, clr_idx_d;

  // global history
  logic [HISTORY_BITS-1:0] hist_q, hist_d;

  // read stage
  logic                  s1_valid_q, s1_valid_d;
  logic [INDEX_BITS-1:0] s1_idx_q;
  logic                  s1_taken_q;
  logic                  s1_byp_q;
  gbp_pkg::ctr_t         s1_byp_ctr_q;

  // result register
  logic out_valid_q, out_valid_d;
  logic out_pred_q;
  logic out_misp_q;

  logic                  accept;
  logic                  s1_adv;
  logic [ExtW-1:0]       idx_ext;
  logic [INDEX_BITS-1:0] rd_idx;
  gbp_pkg::ctr_t         rdata;
  gbp_pkg::ctr_t         cur_ctr;
  gbp_pkg::ctr_t         new_ctr;
  logic                  cur_pred;
  logic                  ram_we;
  logic [INDEX_BITS-1:0] ram_waddr;
  gbp_pkg::ctr_t         ram_wdata;

  // handshakes
  assign s1_adv      = s1_valid_q && (!out_valid_q || res_o.ready);
  assign br_i.ready  = !clearing_q && (!s1_valid_q || s1_adv);
  assign accept      = br_i.valid && br_i.ready;

  // table index from address and history, both zero-extended
  assign idx_ext = ExtW'(br_i.pc_low_bits) ^ ExtW'(hist_q);
  assign rd_idx  = idx_ext[INDEX_BITS-1:0];

  // counter lookup with forwarding of the write made at the read edge
  assign cur_ctr  = s1_byp_q ? s1_byp_ctr_q : rdata;
  assign cur_pred = cur_ctr[1];
  assign new_ctr  = gbp_pkg::next_counter(cur_ctr, s1_taken_q);

  // ram write: clearing pass or counter update
  assign ram_we    = clearing_q || s1_adv;
  assign ram_waddr = clearing_q ? clr_idx_q : s1_idx_q;
  assign ram_wdata = clearing_q ? gbp_pkg::CtrWeakNt : new_ctr;

  gbp_ram #(
    .Width ($bits(gbp_pkg::ctr_t)),
    .Depth (Depth)
  ) u_ctr_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (accept),
    .raddr_i (rd_idx),
    .rdata_o (rdata)
  );

  // control next state
  always_comb begin
    clearing_d  = clearing_q;
    clr_idx_d   = clr_idx_q;
    hist_d      = hist_q;
    s1_valid_d  = s1_valid_q;
    out_valid_d = out_valid_q;
    if (clearing_q) begin
      clr_idx_d = clr_idx_q + INDEX_BITS'(1);
      if (&clr_idx_q) begin
        clearing_d = 1'b0;
      end
    end
    if (accept) begin
      hist_d = HISTORY_BITS'({hist_q, br_i.taken});
    end
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    if (s1_adv) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q  <= 1'b1;
      clr_idx_q   <= '0;
      hist_q      <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      clearing_q  <= clearing_d;
      clr_idx_q   <= clr_idx_d;
      hist_q      <= hist_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // read stage payload, with a forward flag when the entry is written now
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_idx_q     <= rd_idx;
      s1_taken_q   <= br_i.taken;
      s1_byp_q     <= s1_adv && (s1_idx_q == rd_idx);
      s1_byp_ctr_q <= new_ctr;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_pred_q <= cur_pred;
      out_misp_q <= cur_pred ^ s1_taken_q;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.prediction   = out_pred_q;
  assign res_o.mispredicted = out_misp_q;

endmodule

`default_nettype wire
